@@ rtl/core/point_line_segment_projection_assert.svh @@
// assertion macros shared by the point line segment projection rtl
`ifndef POINT_LINE_SEGMENT_PROJECTION_ASSERT_SVH
`define POINT_LINE_SEGMENT_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PLSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plsp assertion failed");
// next-cycle implication
`define PLSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plsp assertion failed");
`else
`define PLSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PLSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/plsp_pkg.sv @@
// shared types, codes and constants of the point line segment projection block
package plsp_pkg;

   // query kinds
   localparam logic OP_SEGMENT = 1'b0;
   localparam logic OP_LINE    = 1'b1;

   // which case produced the closest point
   typedef enum logic [1:0] {
      REGION_START      = 2'd0,
      REGION_INTERIOR   = 2'd1,
      REGION_END        = 2'd2,
      REGION_DEGENERATE = 2'd3
   } region_type;

   // squared distance port
   localparam int DIST_BITS = 33;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   // queue between front and back
   localparam int QUEUE_DEPTH      = 8;
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // width of one classified entry for a given coordinate width
   function automatic int entry_bits(input int coord_bits);
      return 16 * coord_bits + 17;
   endfunction

endpackage

@@ rtl/core/plsp_front.sv @@
// front end: accepts queries, forms dot and cross products, classifies the region
module plsp_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            accept,
   input  logic                                            op,
   input  logic signed [COORD_BITS-1:0]                    point_x,
   input  logic signed [COORD_BITS-1:0]                    point_y,
   input  logic signed [COORD_BITS-1:0]                    anchor_x,
   input  logic signed [COORD_BITS-1:0]                    anchor_y,
   input  logic signed [COORD_BITS-1:0]                    second_x,
   input  logic signed [COORD_BITS-1:0]                    second_y,
   output logic                                            entry_valid,
   output logic [plsp_pkg::entry_bits(COORD_BITS)-1:0]     entry_data,
   output logic [1:0]                                      inflight
);

   localparam int W1 = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int SW = 2 * COORD_BITS + 3;

   // stage 0: offsets
   logic signed [W1-1:0] px_e, py_e, ax_e, ay_e, sx_e, sy_e;
   logic signed [W1-1:0] wx_in, wy_in, dx_in, dy_in, ex_in, ey_in;
   logic signed [W1-1:0] wx_f0_ff, wy_f0_ff, dx_f0_ff, dy_f0_ff, ex_f0_ff, ey_f0_ff;
   logic signed [COORD_BITS-1:0] ax_f0_ff, ay_f0_ff, sx_f0_ff, sy_f0_ff;
   logic op_f0_ff, valid_f0_ff;

   // stage 1: products
   logic signed [PW-1:0] m_wxdx_ff, m_wydy_ff, m_wxdy_ff, m_wydx_ff;
   logic signed [PW-1:0] m_dxdx_ff, m_dydy_ff, m_wxwx_ff, m_wywy_ff, m_exex_ff, m_eyey_ff;
   logic [W1-1:0] adx_in, ady_in, adx_f1_ff, ady_f1_ff, adx_f2_ff, ady_f2_ff;
   logic sdx_f1_ff, sdy_f1_ff, sdx_f2_ff, sdy_f2_ff;
   logic signed [COORD_BITS-1:0] ax_f1_ff, ay_f1_ff, sx_f1_ff, sy_f1_ff;
   logic signed [COORD_BITS-1:0] ax_f2_ff, ay_f2_ff, sx_f2_ff, sy_f2_ff;
   logic op_f1_ff, valid_f1_ff, op_f2_ff, valid_f2_ff;

   // stage 2: sums
   logic signed [SW-1:0] proj_f2_ff, cross_f2_ff, vsq_f2_ff, wsq_f2_ff, esq_f2_ff;

   // classification
   logic                       pneg;
   logic [PW-1:0]              pm, cm;
   plsp_pkg::region_type       region;

   // sign extension of the coordinates
   always_comb begin
      px_e = {point_x[COORD_BITS-1], point_x};
      py_e = {point_y[COORD_BITS-1], point_y};
      ax_e = {anchor_x[COORD_BITS-1], anchor_x};
      ay_e = {anchor_y[COORD_BITS-1], anchor_y};
      sx_e = {second_x[COORD_BITS-1], second_x};
      sy_e = {second_y[COORD_BITS-1], second_y};
      wx_in = px_e - ax_e;
      wy_in = py_e - ay_e;
      ex_in = px_e - sx_e;
      ey_in = py_e - sy_e;
      dx_in = (op == plsp_pkg::OP_LINE) ? sx_e : sx_e - ax_e;
      dy_in = (op == plsp_pkg::OP_LINE) ? sy_e : sy_e - ay_e;
   end

   // direction magnitudes
   always_comb begin
      adx_in = dx_f0_ff[W1-1] ? W1'(-dx_f0_ff) : W1'(dx_f0_ff);
      ady_in = dy_f0_ff[W1-1] ? W1'(-dy_f0_ff) : W1'(dy_f0_ff);
   end

   // valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f0_ff <= 1'b0;
         valid_f1_ff <= 1'b0;
         valid_f2_ff <= 1'b0;
      end else begin
         valid_f0_ff <= accept;
         valid_f1_ff <= valid_f0_ff;
         valid_f2_ff <= valid_f1_ff;
      end
   end

   // payload of the three stages
   always_ff @(posedge clock) begin
      wx_f0_ff <= wx_in;
      wy_f0_ff <= wy_in;
      dx_f0_ff <= dx_in;
      dy_f0_ff <= dy_in;
      ex_f0_ff <= ex_in;
      ey_f0_ff <= ey_in;
      ax_f0_ff <= anchor_x;
      ay_f0_ff <= anchor_y;
      sx_f0_ff <= second_x;
      sy_f0_ff <= second_y;
      op_f0_ff <= op;

      m_wxdx_ff <= wx_f0_ff * dx_f0_ff;
      m_wydy_ff <= wy_f0_ff * dy_f0_ff;
      m_wxdy_ff <= wx_f0_ff * dy_f0_ff;
      m_wydx_ff <= wy_f0_ff * dx_f0_ff;
      m_dxdx_ff <= dx_f0_ff * dx_f0_ff;
      m_dydy_ff <= dy_f0_ff * dy_f0_ff;
      m_wxwx_ff <= wx_f0_ff * wx_f0_ff;
      m_wywy_ff <= wy_f0_ff * wy_f0_ff;
      m_exex_ff <= ex_f0_ff * ex_f0_ff;
      m_eyey_ff <= ey_f0_ff * ey_f0_ff;
      adx_f1_ff <= adx_in;
      ady_f1_ff <= ady_in;
      sdx_f1_ff <= dx_f0_ff[W1-1];
      sdy_f1_ff <= dy_f0_ff[W1-1];
      ax_f1_ff  <= ax_f0_ff;
      ay_f1_ff  <= ay_f0_ff;
      sx_f1_ff  <= sx_f0_ff;
      sy_f1_ff  <= sy_f0_ff;
      op_f1_ff  <= op_f0_ff;

      proj_f2_ff  <= SW'(m_wxdx_ff) + SW'(m_wydy_ff);
      cross_f2_ff <= SW'(m_wxdy_ff) - SW'(m_wydx_ff);
      vsq_f2_ff   <= SW'(m_dxdx_ff) + SW'(m_dydy_ff);
      wsq_f2_ff   <= SW'(m_wxwx_ff) + SW'(m_wywy_ff);
      esq_f2_ff   <= SW'(m_exex_ff) + SW'(m_eyey_ff);
      adx_f2_ff   <= adx_f1_ff;
      ady_f2_ff   <= ady_f1_ff;
      sdx_f2_ff   <= sdx_f1_ff;
      sdy_f2_ff   <= sdy_f1_ff;
      ax_f2_ff    <= ax_f1_ff;
      ay_f2_ff    <= ay_f1_ff;
      sx_f2_ff    <= sx_f1_ff;
      sy_f2_ff    <= sy_f1_ff;
      op_f2_ff    <= op_f1_ff;
   end

   // magnitudes and region decision
   always_comb begin
      pneg = proj_f2_ff[SW-1];
      pm   = PW'(pneg ? -proj_f2_ff : proj_f2_ff);
      cm   = PW'(cross_f2_ff[SW-1] ? -cross_f2_ff : cross_f2_ff);
      if (op_f2_ff == plsp_pkg::OP_LINE && vsq_f2_ff == '0) begin
         region = plsp_pkg::REGION_DEGENERATE;
      end else if (op_f2_ff == plsp_pkg::OP_SEGMENT && (pneg || proj_f2_ff == '0)) begin
         region = plsp_pkg::REGION_START;
      end else if (op_f2_ff == plsp_pkg::OP_SEGMENT && proj_f2_ff >= vsq_f2_ff) begin
         region = plsp_pkg::REGION_END;
      end else begin
         region = plsp_pkg::REGION_INTERIOR;
      end
   end

   // entry packing
   assign entry_valid = valid_f2_ff;
   assign entry_data  = {2'(region), pneg, sdx_f2_ff, sdy_f2_ff, adx_f2_ff, ady_f2_ff,
                         pm, cm, PW'(vsq_f2_ff), PW'(wsq_f2_ff), PW'(esq_f2_ff),
                         ax_f2_ff, ay_f2_ff, sx_f2_ff, sy_f2_ff};
   assign inflight    = 2'(valid_f0_ff) + 2'(valid_f1_ff) + 2'(valid_f2_ff);

endmodule

@@ rtl/core/plsp_queue.sv @@
// queue of classified entries between front and back
`include "point_line_segment_projection_assert.svh"

module plsp_queue #(
   parameter int WIDTH = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   output logic                                   rd_valid,
   output logic [WIDTH-1:0]                       rd_data,
   output logic [plsp_pkg::QUEUE_COUNT_BITS-1:0]  count
);

   localparam int D  = plsp_pkg::QUEUE_DEPTH;
   localparam int PB = $clog2(D);
   localparam int CB = plsp_pkg::QUEUE_COUNT_BITS;

   logic [WIDTH-1:0] mem_ff [D];
   logic [PB-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0]    count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (!wr_en && rd_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

   `PLSP_ASSERT_IMPLY(a_no_write_when_full, clock, reset, wr_en, count_ff != CB'(D))
   `PLSP_ASSERT_IMPLY(a_no_read_when_empty, clock, reset, rd_en, count_ff != '0)
   `PLSP_ASSERT_NEXT(a_count_grows, clock, reset, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ rtl/core/plsp_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module plsp_div #(
   parameter int NUM_BITS = 68,
   parameter int DIV_BITS = 34,
   parameter int QUO_BITS = 34
) (
   input  logic                clock,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DIV_BITS-1:0] divisor,
   output logic [QUO_BITS-1:0] quotient
);

   logic [DIV_BITS-1:0] rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0] low_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];
   logic [DIV_BITS-1:0] dvs_ff [QUO_BITS];

   logic [DIV_BITS-1:0] s_rem [QUO_BITS];
   logic [QUO_BITS-1:0] s_low [QUO_BITS];
   logic [QUO_BITS-1:0] s_quo [QUO_BITS];
   logic [DIV_BITS-1:0] s_dvs [QUO_BITS];

   // first stage takes the high numerator bits as partial remainder
   always_comb begin
      s_rem[0] = DIV_BITS'(num >> QUO_BITS);
      s_low[0] = num[QUO_BITS-1:0];
      s_quo[0] = '0;
      s_dvs[0] = divisor;
      for (int k = 1; k < QUO_BITS; k++) begin
         s_rem[k] = rem_ff[k-1];
         s_low[k] = low_ff[k-1];
         s_quo[k] = quo_ff[k-1];
         s_dvs[k] = dvs_ff[k-1];
      end
   end

   // one trial subtraction per stage
   for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
      logic [DIV_BITS:0] trial, diff;
      logic              ge;
      always_comb begin
         trial = {s_rem[g], s_low[g][QUO_BITS-1]};
         diff  = trial - {1'b0, s_dvs[g]};
         ge    = (trial >= {1'b0, s_dvs[g]});
      end
      always_ff @(posedge clock) begin
         rem_ff[g] <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         low_ff[g] <= s_low[g] << 1;
         quo_ff[g] <= {s_quo[g][QUO_BITS-2:0], ge};
         dvs_ff[g] <= s_dvs[g];
      end
   end

   assign quotient = quo_ff[QUO_BITS-1];

endmodule

@@ rtl/core/plsp_back.sv @@
// back end: projection and distance divisions, clamping and result register
`include "point_line_segment_projection_assert.svh"

module plsp_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         head_valid,
   input  logic [plsp_pkg::entry_bits(COORD_BITS)-1:0]  head_data,
   output logic                                         pop,
   output logic                                         rsp_valid,
   output logic signed [COORD_BITS-1:0]                 rsp_closest_x,
   output logic signed [COORD_BITS-1:0]                 rsp_closest_y,
   output logic [plsp_pkg::DIST_BITS-1:0]               rsp_dist_sq,
   output logic [1:0]                                   rsp_region,
   output logic                                         rsp_saturated
);

   localparam int C    = COORD_BITS;
   localparam int W1   = C + 1;
   localparam int PW   = 2 * C + 2;
   localparam int QB   = PW;
   localparam int NXB  = 3 * C + 4;
   localparam int NDB  = 4 * C + 5;
   localparam int XW   = C + 3;
   localparam int DB   = plsp_pkg::DIST_BITS;
   localparam int XDW  = (PW > DB) ? PW : DB;
   localparam int SIDE = 4 + 2 * PW + 4 * C;

   localparam int O_SY   = 0;
   localparam int O_SX   = C;
   localparam int O_AY   = 2 * C;
   localparam int O_AX   = 3 * C;
   localparam int O_ESQ  = 4 * C;
   localparam int O_WSQ  = O_ESQ + PW;
   localparam int O_VSQ  = O_WSQ + PW;
   localparam int O_CM   = O_VSQ + PW;
   localparam int O_PM   = O_CM + PW;
   localparam int O_ADY  = O_PM + PW;
   localparam int O_ADX  = O_ADY + W1;
   localparam int O_SDY  = O_ADX + W1;
   localparam int O_SDX  = O_SDY + 1;
   localparam int O_PNEG = O_SDX + 1;
   localparam int O_REG  = O_PNEG + 1;

   // entry fields
   logic [W1-1:0] h_adx, h_ady;
   logic [PW-1:0] h_pm, h_cm;

   // stage b0: partial products
   logic                b0_valid_ff;
   logic [PW-1:0]       b0_xlo_ff, b0_xhi_ff, b0_ylo_ff, b0_yhi_ff;
   logic [PW-1:0]       b0_cll_ff, b0_clh_ff, b0_chh_ff;
   logic [PW-1:0]       b0_vsq_ff;
   logic [SIDE-1:0]     b0_side_ff;

   // stage b1: numerators
   logic                b1_valid_ff;
   logic [NXB-1:0]      b1_nx_ff, b1_ny_ff;
   logic [NDB-1:0]      b1_nd_ff;
   logic [PW-1:0]       b1_vsq_ff;
   logic [SIDE-1:0]     b1_side_ff;

   // side band beside the dividers
   logic                dv_valid_ff [QB];
   logic [SIDE-1:0]     dv_side_ff  [QB];
   logic [QB-1:0]       quo_x, quo_y, quo_d;

   // output stage
   logic [1:0]           o_region;
   logic                 o_negx, o_negy;
   logic [PW-1:0]        o_wsq, o_esq;
   logic signed [C-1:0]  o_ax, o_ay, o_sx, o_sy;
   logic signed [XW-1:0] ax_w, ay_w, qx_w, qy_w, cx_full, cy_full;
   logic                 ovf_x, ovf_y;
   logic signed [C-1:0]  cx_clamp, cy_clamp;
   logic signed [C-1:0]  cx_in, cy_in;
   logic [PW-1:0]        dsel;
   logic [XDW-1:0]       dwide;
   logic                 sat_in;

   logic                 rsp_valid_ff, rsp_saturated_ff;
   logic signed [C-1:0]  rsp_closest_x_ff, rsp_closest_y_ff;
   logic [DB-1:0]        rsp_dist_sq_ff;
   plsp_pkg::region_type rsp_region_ff;

   assign pop   = head_valid;
   assign h_adx = head_data[O_ADX +: W1];
   assign h_ady = head_data[O_ADY +: W1];
   assign h_pm  = head_data[O_PM +: PW];
   assign h_cm  = head_data[O_CM +: PW];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < QB; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else begin
         b0_valid_ff    <= head_valid;
         b1_valid_ff    <= b0_valid_ff;
         dv_valid_ff[0] <= b1_valid_ff;
         for (int k = 1; k < QB; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         rsp_valid_ff <= dv_valid_ff[QB-1];
      end
   end

   // split products and numerator sums
   always_ff @(posedge clock) begin
      b0_xlo_ff  <= PW'(h_adx) * PW'(h_pm[W1-1:0]);
      b0_xhi_ff  <= PW'(h_adx) * PW'(h_pm[PW-1:W1]);
      b0_ylo_ff  <= PW'(h_ady) * PW'(h_pm[W1-1:0]);
      b0_yhi_ff  <= PW'(h_ady) * PW'(h_pm[PW-1:W1]);
      b0_cll_ff  <= PW'(h_cm[W1-1:0]) * PW'(h_cm[W1-1:0]);
      b0_clh_ff  <= PW'(h_cm[W1-1:0]) * PW'(h_cm[PW-1:W1]);
      b0_chh_ff  <= PW'(h_cm[PW-1:W1]) * PW'(h_cm[PW-1:W1]);
      b0_vsq_ff  <= head_data[O_VSQ +: PW];
      b0_side_ff <= {head_data[O_REG +: 2],
                     head_data[O_SDX] ^ head_data[O_PNEG],
                     head_data[O_SDY] ^ head_data[O_PNEG],
                     head_data[O_WSQ +: PW], head_data[O_ESQ +: PW],
                     head_data[O_AX +: C], head_data[O_AY +: C],
                     head_data[O_SX +: C], head_data[O_SY +: C]};

      b1_nx_ff   <= (NXB'(b0_xhi_ff) << W1) + NXB'(b0_xlo_ff) + NXB'(b0_vsq_ff >> 1);
      b1_ny_ff   <= (NXB'(b0_yhi_ff) << W1) + NXB'(b0_ylo_ff) + NXB'(b0_vsq_ff >> 1);
      b1_nd_ff   <= (NDB'(b0_chh_ff) << (2 * W1)) + (NDB'(b0_clh_ff) << (W1 + 1))
                    + NDB'(b0_cll_ff) + NDB'(b0_vsq_ff >> 1);
      b1_vsq_ff  <= b0_vsq_ff;
      b1_side_ff <= b0_side_ff;

      dv_side_ff[0] <= b1_side_ff;
      for (int k = 1; k < QB; k++) begin
         dv_side_ff[k] <= dv_side_ff[k-1];
      end
   end

   plsp_div #(.NUM_BITS(NXB), .DIV_BITS(PW), .QUO_BITS(QB)) u_div_x (
      .clock    (clock),
      .num      (b1_nx_ff),
      .divisor  (b1_vsq_ff),
      .quotient (quo_x)
   );

   plsp_div #(.NUM_BITS(NXB), .DIV_BITS(PW), .QUO_BITS(QB)) u_div_y (
      .clock    (clock),
      .num      (b1_ny_ff),
      .divisor  (b1_vsq_ff),
      .quotient (quo_y)
   );

   plsp_div #(.NUM_BITS(NDB), .DIV_BITS(PW), .QUO_BITS(QB)) u_div_d (
      .clock    (clock),
      .num      (b1_nd_ff),
      .divisor  (b1_vsq_ff),
      .quotient (quo_d)
   );

   // unpack side band at the divider output
   always_comb begin
      {o_region, o_negx, o_negy, o_wsq, o_esq, o_ax, o_ay, o_sx, o_sy} =
         dv_side_ff[QB-1];
   end

   // projected point and clamp to the coordinate range
   always_comb begin
      ax_w    = XW'(o_ax);
      ay_w    = XW'(o_ay);
      qx_w    = XW'(quo_x[C+1:0]);
      qy_w    = XW'(quo_y[C+1:0]);
      cx_full = o_negx ? ax_w - qx_w : ax_w + qx_w;
      cy_full = o_negy ? ay_w - qy_w : ay_w + qy_w;
      ovf_x   = !(&cx_full[XW-1:C-1]) && (|cx_full[XW-1:C-1]);
      ovf_y   = !(&cy_full[XW-1:C-1]) && (|cy_full[XW-1:C-1]);
      cx_clamp = ovf_x ? (cx_full[XW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}})
                       : cx_full[C-1:0];
      cy_clamp = ovf_y ? (cy_full[XW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}})
                       : cy_full[C-1:0];
   end

   // result selection by region
   always_comb begin
      case (o_region)
         plsp_pkg::REGION_INTERIOR: begin
            cx_in  = cx_clamp;
            cy_in  = cy_clamp;
            dsel   = quo_d;
            sat_in = ovf_x || ovf_y;
         end
         plsp_pkg::REGION_END: begin
            cx_in  = o_sx;
            cy_in  = o_sy;
            dsel   = o_esq;
            sat_in = 1'b0;
         end
         default: begin
            cx_in  = o_ax;
            cy_in  = o_ay;
            dsel   = o_wsq;
            sat_in = 1'b0;
         end
      endcase
      dwide = XDW'(dsel);
   end

   // result register
   always_ff @(posedge clock) begin
      rsp_closest_x_ff <= cx_in;
      rsp_closest_y_ff <= cy_in;
      rsp_dist_sq_ff   <= (dwide > XDW'(plsp_pkg::DIST_MAX)) ? plsp_pkg::DIST_MAX
                                                             : DB'(dwide);
      rsp_region_ff    <= plsp_pkg::region_type'(o_region);
      rsp_saturated_ff <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_closest_x = rsp_closest_x_ff;
   assign rsp_closest_y = rsp_closest_y_ff;
   assign rsp_dist_sq   = rsp_dist_sq_ff;
   assign rsp_region    = 2'(rsp_region_ff);
   assign rsp_saturated = rsp_saturated_ff;

   `PLSP_ASSERT_IMPLY(a_sat_only_interior, clock, reset, rsp_valid_ff && rsp_saturated_ff, rsp_region_ff == plsp_pkg::REGION_INTERIOR)
   `PLSP_ASSERT_NEXT(a_head_enters, clock, reset, head_valid, b0_valid_ff)
   `PLSP_ASSERT_NEXT(a_no_phantom, clock, reset, !head_valid, !b0_valid_ff)

endmodule

@@ rtl/core/point_line_segment_projection.sv @@
// top level: closest point and squared distance from a point to a segment or line
//
// Command channel: a query is taken at a rising edge with start high and busy low.
// req_op selects a segment (req_second_* is the end point) or an infinite line
// (req_second_* is the direction). Each query yields one beat on the result
// channel: rsp_valid is high for exactly one cycle with the closest point, the
// squared distance, the region code and the saturation flag.
// The result path runs through the three-stage front end, the queue, two product
// and numerator stages, the one-bit-per-stage divider chain of 2*COORD_BITS + 2
// stages and the result register. Throughput is one query per cycle; busy rises
// only if the queue between the front and back ends would run out of room, which
// a back end that drains every cycle never lets happen. Results come out in
// accept order. The receiver cannot stall the result beat.
// Synchronous reset empties the pipeline and queue; no result beat is issued
// for a query still in flight at reset.
module point_line_segment_projection #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_op,
   input  logic signed [COORD_BITS-1:0]           req_point_x,
   input  logic signed [COORD_BITS-1:0]           req_point_y,
   input  logic signed [COORD_BITS-1:0]           req_anchor_x,
   input  logic signed [COORD_BITS-1:0]           req_anchor_y,
   input  logic signed [COORD_BITS-1:0]           req_second_x,
   input  logic signed [COORD_BITS-1:0]           req_second_y,
   output logic                                   rsp_valid,
   output logic signed [COORD_BITS-1:0]           rsp_closest_x,
   output logic signed [COORD_BITS-1:0]           rsp_closest_y,
   output logic [plsp_pkg::DIST_BITS-1:0]         rsp_dist_sq,
   output logic [1:0]                             rsp_region,
   output logic                                   rsp_saturated
);

   localparam int EW = plsp_pkg::entry_bits(COORD_BITS);
   localparam int CB = plsp_pkg::QUEUE_COUNT_BITS;

   logic          accept;
   logic          entry_valid;
   logic [EW-1:0] entry_data;
   logic [1:0]    inflight;
   logic          head_valid, pop;
   logic [EW-1:0] head_data;
   logic [CB-1:0] q_count;
   logic [CB:0]   credits_used;

   // hold off a beat when front stages plus queue could overfill the queue
   assign credits_used = (CB + 1)'(inflight) + (CB + 1)'(q_count);
   assign busy         = (credits_used >= (CB + 1)'(plsp_pkg::QUEUE_DEPTH));
   assign accept       = start && !busy;

   plsp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .anchor_x    (req_anchor_x),
      .anchor_y    (req_anchor_y),
      .second_x    (req_second_x),
      .second_y    (req_second_y),
      .entry_valid (entry_valid),
      .entry_data  (entry_data),
      .inflight    (inflight)
   );

   plsp_queue #(.WIDTH(EW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_valid),
      .wr_data  (entry_data),
      .rd_en    (pop),
      .rd_valid (head_valid),
      .rd_data  (head_data),
      .count    (q_count)
   );

   plsp_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_closest_x (rsp_closest_x),
      .rsp_closest_y (rsp_closest_y),
      .rsp_dist_sq   (rsp_dist_sq),
      .rsp_region    (rsp_region),
      .rsp_saturated (rsp_saturated)
   );

endmodule
